>>> src/dllfl_pkg.sv
// shared types and constants for the doubly linked list with free list core
// no dependencies
package dllfl_pkg;

  localparam int ACTION_W    = 2;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 5;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - SLOT_W;
  localparam int Q_DEPTH     = 2;

  typedef enum logic [ACTION_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_LIST_FWD = 2'd2,
    OP_LIST_REV = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_INS,
    BK_DEL,
    BK_WALK
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

>>> src/dllfl_front.sv
// front end: accepts input beats, decodes the action and queues commands
// depends on dllfl_pkg
module dllfl_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [dllfl_pkg::VALUE_W-1:0]  in_tdata,   // value
  input  logic [dllfl_pkg::ACTION_W-1:0] in_tuser,   // action
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output dllfl_pkg::cmd_t              cmd
);
  import dllfl_pkg::*;

  localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  cmd_t           q_r [Q_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push, pop;
  cmd_t           dec;

  always_comb begin
    dec.op    = op_t'(in_tuser);
    dec.value = in_tdata;
  end

  assign in_tready = (cnt_r != QCW'(Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> src/dllfl_back.sv
// back end: link memories, head/tail/free pointers, operation sequencer
// and result register; depends on dllfl_pkg
module dllfl_back #(
  parameter int SLOTS      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  dllfl_pkg::cmd_t                  cmd,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dllfl_pkg::OUT_TDATA_W-1:0] out_tdata,  // data_word, slot, zero pad
  output logic [dllfl_pkg::STATUS_W-1:0]    out_tuser,  // status
  output logic                             out_tlast
);
  import dllfl_pkg::*;

  localparam int PW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  back_state_t state_r, state_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] free_r, free_nxt;
  logic [PW-1:0] k_r, k_nxt;
  logic          fwd_r, fwd_nxt;

  logic [PW-1:0]         next_mem [SLOTS];
  logic [PW-1:0]         prev_mem [SLOTS];
  logic [DATA_WIDTH-1:0] data_mem [SLOTS];
  logic [SLOTS-1:0]      next_vld_r;

  logic [PW-1:0]         rd_next_r, rd_prev_r, rd_addr_r;
  logic                  rd_nvld_r;
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic                  rd_en;
  logic [PW-1:0]         rd_addr;
  logic                  nwr_en, pwr_en, dwr_en;
  logic [PW-1:0]         nwr_addr, nwr_data, pwr_addr, pwr_data, dwr_addr;
  logic [DATA_WIDTH-1:0] dwr_data;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [VALUE_W-1:0]    out_data_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic                  out_last_r;

  logic                  out_free, emit, em_last;
  status_t               em_status;
  logic [VALUE_W-1:0]    em_data;
  logic [PW-1:0]         em_slot;

  logic [PW-1:0]         link_eff, walk_nx, start_p;
  logic                  walk_fin;
  logic [DATA_WIDTH+VALUE_W-1:0] sext_val, zext_data;
  logic [PW+SLOT_W-1:0]  slot_ext;

  assign out_free  = !out_valid_r || out_tready;
  assign link_eff  = rd_nvld_r ? rd_next_r : rd_addr_r + 1'b1;
  assign walk_nx   = fwd_r ? link_eff : rd_prev_r;
  assign walk_fin  = !(walk_nx < NIL) || (k_r == PW'(SLOTS - 1));
  assign start_p   = (cmd.op == OP_LIST_FWD) ? head_r : tail_r;
  assign sext_val  = {{DATA_WIDTH{cmd.value[VALUE_W-1]}}, cmd.value};
  assign zext_data = {{VALUE_W{1'b0}}, rd_data_r};
  assign slot_ext  = {{SLOT_W{1'b0}}, em_slot};

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    free_nxt  = free_r;
    k_nxt     = k_r;
    fwd_nxt   = fwd_r;
    cmd_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    nwr_en    = 1'b0;
    nwr_addr  = head_r;
    nwr_data  = free_r;
    pwr_en    = 1'b0;
    pwr_addr  = free_r;
    pwr_data  = NIL;
    dwr_en    = 1'b0;
    dwr_addr  = free_r;
    dwr_data  = sext_val[DATA_WIDTH-1:0];
    emit      = 1'b0;
    em_status = ST_OK;
    em_data   = '0;
    em_slot   = NIL;
    em_last   = 1'b1;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd.op)
            OP_INSERT: begin
              if (free_r >= NIL) begin
                emit      = 1'b1;
                em_status = ST_OVERFLOW;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = free_r;
                dwr_en    = 1'b1;
                pwr_en    = 1'b1;
                state_nxt = BK_INS;
              end
            end
            OP_DELETE: begin
              if (head_r >= NIL) begin
                emit      = 1'b1;
                em_status = ST_UNDERFLOW;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                state_nxt = BK_DEL;
              end
            end
            OP_LIST_FWD, OP_LIST_REV: begin
              fwd_nxt = (cmd.op == OP_LIST_FWD);
              if (start_p >= NIL) begin
                emit      = 1'b1;
                em_status = ST_UNDERFLOW;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = start_p;
                k_nxt     = '0;
                state_nxt = BK_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_INS: begin
        if (out_free) begin
          free_nxt = link_eff;
          nwr_en   = 1'b1;
          nwr_addr = free_r;
          nwr_data = head_r;
          if (head_r < NIL) begin
            pwr_en   = 1'b1;
            pwr_addr = head_r;
            pwr_data = free_r;
          end else begin
            tail_nxt = free_r;
          end
          head_nxt  = free_r;
          emit      = 1'b1;
          em_slot   = free_r;
          state_nxt = BK_IDLE;
        end
      end
      BK_DEL: begin
        if (out_free) begin
          if (link_eff < NIL) begin
            pwr_en   = 1'b1;
            pwr_addr = link_eff;
            head_nxt = link_eff;
            em_slot  = link_eff;
          end else begin
            head_nxt = NIL;
            tail_nxt = NIL;
          end
          nwr_en    = 1'b1;
          nwr_addr  = head_r;
          nwr_data  = free_r;
          free_nxt  = head_r;
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      BK_WALK: begin
        if (out_free) begin
          emit    = 1'b1;
          em_data = zext_data[VALUE_W-1:0];
          em_slot = rd_addr_r;
          em_last = walk_fin;
          if (walk_fin) begin
            state_nxt = BK_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = walk_nx;
            k_nxt   = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      free_r      <= '0;
      k_r         <= '0;
      fwd_r       <= 1'b0;
      next_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      k_r     <= k_nxt;
      fwd_r   <= fwd_nxt;
      if (nwr_en) begin
        next_vld_r[nwr_addr[IW-1:0]] <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nwr_en) begin
      next_mem[nwr_addr[IW-1:0]] <= nwr_data;
    end
    if (pwr_en) begin
      prev_mem[pwr_addr[IW-1:0]] <= pwr_data;
    end
    if (dwr_en) begin
      data_mem[dwr_addr[IW-1:0]] <= dwr_data;
    end
    if (rd_en) begin
      rd_next_r <= next_mem[rd_addr[IW-1:0]];
      rd_nvld_r <= next_vld_r[rd_addr[IW-1:0]];
      rd_prev_r <= prev_mem[rd_addr[IW-1:0]];
      rd_data_r <= data_mem[rd_addr[IW-1:0]];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= em_status;
      out_data_r   <= em_data;
      out_slot_r   <= slot_ext[SLOT_W-1:0];
      out_last_r   <= em_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_slot_r, out_data_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  a_head_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r >= NIL) == (tail_r >= NIL))
    else $error("head and tail disagree on empty list");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WALK) |-> (k_r < PW'(SLOTS)))
    else $error("walk ran past slot count");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready) |-> (state_r == BK_IDLE))
    else $error("command taken while busy");

  a_free_not_head: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r < NIL) |-> (free_r != head_r))
    else $error("free list head is on the list");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result overwrote pending beat");

endmodule

>>> src/doubly_linked_list_with_free_list_core.sv
// top level of the doubly linked list with free list core
// holds dllfl_front and dllfl_back; depends on dllfl_pkg
// flow: a beat is queued in dllfl_front; dllfl_back takes the command while idle,
//   reads the link memories through their registered read port, then registers the result
// listing gives the first node and then one node per cycle while out_tready holds;
//   a new command is taken only once the current one is done and the back end is idle
// reset: empties the list and chains all slots into the free list at once
module doubly_linked_list_with_free_list_core #(
  parameter int SLOTS      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dllfl_pkg::VALUE_W-1:0]     in_tdata,   // value
  input  logic [dllfl_pkg::ACTION_W-1:0]    in_tuser,   // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dllfl_pkg::OUT_TDATA_W-1:0] out_tdata,  // data_word, slot, zero pad
  output logic [dllfl_pkg::STATUS_W-1:0]    out_tuser,  // status
  output logic                             out_tlast
);
  import dllfl_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  dllfl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dllfl_back #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
